@@ rtl/core/kmcd_pkg.sv @@
`default_nettype none

package kmcd_pkg;

    // payload widths
    localparam int KIND_W  = 1;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int CODE_W  = 8;
    localparam int LEVEL_W = 8;

    // configuration port
    localparam int CFG_W   = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] RESET_NUM_ROWS = 4'd8;
    localparam logic [CFG_W-1:0] RESET_NUM_COLS = 4'd8;

    // register index, taken from the word address bit
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_MAP_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE    = 1'b1;

    // matrix size defaults
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;

endpackage

`default_nettype wire

@@ rtl/core/kmcd_ram.sv @@
`default_nettype none

module kmcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/key_matrix_change_detector.sv @@
`default_nettype none

// key matrix change detector: takes one scanned matrix row per item (row index and column
// levels) and emits one press or release item per changed column in use, in rising column
// order, each with its key code from the keymap and the last flag on the final one; a second
// item kind writes one keymap entry. an input item is taken at most once per cycle and moves
// through three stages: previous-level read, event stage, output register. the event stage
// holds a row sample until its final event is read from the keymap and frees at once on a
// keymap write; events leave it one per cycle, set by the single read port of the keymap
// memory, unless the output register stalls. both stores read as zero after reset through
// per-entry valid bits, so no clearing pass is needed.
// num_rows and num_cols should only be written while the block is idle.
module key_matrix_change_detector #(
    parameter int MAX_ROWS = kmcd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kmcd_pkg::DEF_MAX_COLS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kmcd_pkg::PADDR_W-1:0]   paddr,
    input  logic [kmcd_pkg::PDATA_W-1:0]   pwdata,
    output logic [kmcd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [kmcd_pkg::KIND_W-1:0]    s_kind,
    input  logic [kmcd_pkg::ROW_W-1:0]     s_row,
    input  logic [kmcd_pkg::COL_W-1:0]     s_col,
    input  logic [kmcd_pkg::CODE_W-1:0]    s_key_code,
    input  logic [kmcd_pkg::LEVEL_W-1:0]   s_column_levels,
    // event items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_is_release,
    output logic [kmcd_pkg::CODE_W-1:0]    m_event_code,
    output logic [kmcd_pkg::ROW_W-1:0]     m_event_row,
    output logic [kmcd_pkg::COL_W-1:0]     m_event_col,
    output logic                           m_last
);

    import kmcd_pkg::*;

    // address widths of the two stores
    localparam int KDEPTH    = MAX_ROWS * MAX_COLS;
    localparam int RAW       = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
    localparam int KAW       = $clog2(KDEPTH > 1 ? KDEPTH : 2);
    // columns usable at all: limited by the level word as well
    localparam int COL_LIMIT = (MAX_COLS < LEVEL_W) ? MAX_COLS : LEVEL_W;

    // ---------------------------------------------------------------- configuration
    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= RESET_NUM_ROWS;
            num_cols_reg <= RESET_NUM_COLS;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_ROWS: num_rows_reg <= pwdata[CFG_W-1:0];
                REG_NUM_COLS: num_cols_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_NUM_ROWS: prdata = PDATA_W'(num_rows_reg);
            REG_NUM_COLS: prdata = PDATA_W'(num_cols_reg);
            default: prdata = '0;
        endcase
    end

    // rows and columns in use, saturated to the matrix size
    logic [CFG_W:0]       rows_in_use;
    logic [CFG_W-1:0]     cols_in_use;
    logic [LEVEL_W-1:0]   col_mask;

    assign rows_in_use = ({1'b0, num_rows_reg} > (CFG_W+1)'(MAX_ROWS))
                       ? (CFG_W+1)'(MAX_ROWS) : {1'b0, num_rows_reg};
    assign cols_in_use = (num_cols_reg > CFG_W'(COL_LIMIT)) ? CFG_W'(COL_LIMIT) : num_cols_reg;

    always_comb begin
        for (int c = 0; c < LEVEL_W; c++) begin
            col_mask[c] = CFG_W'(c) < cols_in_use;
        end
    end

    // ---------------------------------------------------------------- pipeline control
    logic               s_acc;
    logic               p1_go;
    logic               p2_free;
    logic               p3_free;

    // stage 1: item waits for the previous levels of its row
    logic               p1_vld_reg;
    logic [KIND_W-1:0]  p1_kind_reg;
    logic [ROW_W-1:0]   p1_row_reg;
    logic [COL_W-1:0]   p1_col_reg;
    logic [CODE_W-1:0]  p1_code_reg;
    logic [LEVEL_W-1:0] p1_levels_reg;
    logic               p1_pvld_reg;
    logic               p1_fwd_reg;
    logic [LEVEL_W-1:0] p1_fwd_data_reg;

    // stage 2: event walk or keymap write
    logic               p2_vld_reg;
    logic [KIND_W-1:0]  p2_kind_reg;
    logic [ROW_W-1:0]   p2_row_reg;
    logic [COL_W-1:0]   p2_col_reg;
    logic [CODE_W-1:0]  p2_code_reg;
    logic [LEVEL_W-1:0] p2_rem_reg;
    logic [LEVEL_W-1:0] p2_now_reg;

    // stage 3: output register, key code straight from the keymap read register
    logic               p3_vld_reg;
    logic               p3_rel_reg;
    logic [ROW_W-1:0]   p3_row_reg;
    logic [COL_W-1:0]   p3_col_reg;
    logic               p3_last_reg;
    logic               p3_kvld_reg;

    // ---------------------------------------------------------------- previous-level store
    logic [MAX_ROWS-1:0] prev_vld_reg;
    logic                prev_we;
    logic [RAW-1:0]      prev_rd_addr;
    logic [LEVEL_W-1:0]  prev_rd_data;
    logic [LEVEL_W-1:0]  p1_before;
    logic                p1_row_ok;
    logic [LEVEL_W-1:0]  p1_now;
    logic [LEVEL_W-1:0]  p1_changed;
    logic                fwd_next;

    // out-of-range rows are ignored later, so any in-range address will do for them
    assign prev_rd_addr = (int'(s_row) < MAX_ROWS) ? RAW'(s_row) : '0;

    kmcd_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (MAX_ROWS)
    ) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_we),
        .wr_addr (RAW'(p1_row_reg)),
        .wr_data (p1_now),
        .rd_en   (s_acc),
        .rd_addr (prev_rd_addr),
        .rd_data (prev_rd_data)
    );

    assign p1_before  = p1_fwd_reg ? p1_fwd_data_reg : (p1_pvld_reg ? prev_rd_data : '0);
    assign p1_row_ok  = (p1_kind_reg == KIND_SAMPLE) && ({2'b00, p1_row_reg} < rows_in_use);
    assign p1_now     = p1_levels_reg & col_mask;
    assign p1_changed = p1_row_ok ? (p1_now ^ (p1_before & col_mask)) : '0;
    assign prev_we    = p1_go && p1_row_ok;
    // a write and a read of the same row at one edge: hand the new levels over directly
    assign fwd_next   = prev_we && (s_row == p1_row_reg);

    // ---------------------------------------------------------------- keymap store
    logic [KDEPTH-1:0]  km_vld_reg;
    logic               km_we;
    logic               km_re;
    logic [KAW-1:0]     km_wr_addr;
    logic [KAW-1:0]     km_rd_addr;
    logic [CODE_W-1:0]  km_rd_data;
    logic [COL_W-1:0]   ev_col;
    logic [LEVEL_W-1:0] rem_after;

    // lowest changed column goes first
    always_comb begin
        ev_col = '0;
        for (int i = LEVEL_W - 1; i >= 0; i--) begin
            if (p2_rem_reg[i]) begin
                ev_col = COL_W'(i);
            end
        end
    end

    assign rem_after  = p2_rem_reg & (p2_rem_reg - LEVEL_W'(1));
    assign km_wr_addr = KAW'(int'(p2_row_reg) * MAX_COLS + int'(p2_col_reg));
    assign km_rd_addr = KAW'(int'(p2_row_reg) * MAX_COLS + int'(ev_col));
    assign km_we      = p2_vld_reg && (p2_kind_reg == KIND_MAP_WRITE)
                     && (int'(p2_row_reg) < MAX_ROWS) && (int'(p2_col_reg) < MAX_COLS);
    assign km_re      = p2_vld_reg && (p2_kind_reg == KIND_SAMPLE)
                     && (p2_rem_reg != '0) && p3_free;

    kmcd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (KDEPTH)
    ) u_keymap_ram (
        .aclk    (aclk),
        .wr_en   (km_we),
        .wr_addr (km_wr_addr),
        .wr_data (p2_code_reg),
        .rd_en   (km_re),
        .rd_addr (km_rd_addr),
        .rd_data (km_rd_data)
    );

    // ---------------------------------------------------------------- handshakes
    assign p3_free = !p3_vld_reg || m_ready;
    // event stage frees up on a keymap write, an empty row, or its final event
    assign p2_free = !p2_vld_reg || (p2_kind_reg == KIND_MAP_WRITE) || (p2_rem_reg == '0)
                  || (km_re && (rem_after == '0));
    assign p1_go   = p1_vld_reg && p2_free;
    assign s_ready = !p1_vld_reg || p2_free;
    assign s_acc   = s_valid && s_ready;

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            prev_vld_reg <= '0;
            km_vld_reg   <= '0;
        end else begin
            if (s_acc) begin
                p1_vld_reg <= 1'b1;
            end else if (p1_go) begin
                p1_vld_reg <= 1'b0;
            end
            if (p1_go) begin
                p2_vld_reg <= 1'b1;
            end else if (p2_free) begin
                p2_vld_reg <= 1'b0;
            end
            if (km_re) begin
                p3_vld_reg <= 1'b1;
            end else if (m_ready) begin
                p3_vld_reg <= 1'b0;
            end
            if (prev_we) begin
                prev_vld_reg[RAW'(p1_row_reg)] <= 1'b1;
            end
            if (km_we) begin
                km_vld_reg[km_wr_addr] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_kind_reg     <= s_kind;
            p1_row_reg      <= s_row;
            p1_col_reg      <= s_col;
            p1_code_reg     <= s_key_code;
            p1_levels_reg   <= s_column_levels;
            p1_pvld_reg     <= prev_vld_reg[prev_rd_addr];
            p1_fwd_reg      <= fwd_next;
            p1_fwd_data_reg <= p1_now;
        end
        if (p1_go) begin
            p2_kind_reg <= p1_kind_reg;
            p2_row_reg  <= p1_row_reg;
            p2_col_reg  <= p1_col_reg;
            p2_code_reg <= p1_code_reg;
            p2_rem_reg  <= p1_changed;
            p2_now_reg  <= p1_now;
        end else if (km_re) begin
            p2_rem_reg <= rem_after;
        end
        if (km_re) begin
            p3_rel_reg  <= !p2_now_reg[ev_col];
            p3_row_reg  <= p2_row_reg;
            p3_col_reg  <= ev_col;
            p3_last_reg <= (rem_after == '0);
            p3_kvld_reg <= km_vld_reg[km_rd_addr];
        end
    end

    assign m_valid      = p3_vld_reg;
    assign m_is_release = p3_rel_reg;
    assign m_event_code = p3_kvld_reg ? km_rd_data : '0;
    assign m_event_row  = p3_row_reg;
    assign m_event_col  = p3_col_reg;
    assign m_last       = p3_last_reg;

    // ---------------------------------------------------------------- checks
    // the keymap is never written while an event read is in flight in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn) !(km_we && km_re))
        else $error("keymap read and write in the same cycle");

    // events only come from columns in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_event_col} < cols_in_use))
        else $error("event from a column not in use");

    // events only come from rows in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({2'b00, m_event_row} < rows_in_use))
        else $error("event from a row not in use");

    // a forwarded level word only follows a write to the same row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && fwd_next) |=> (p1_fwd_reg && prev_vld_reg[RAW'(p1_row_reg)]))
        else $error("forwarding without a matching previous-level write");

endmodule

`default_nettype wire
